// ----- rtl/hmtp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the height map token parser.
// Holds parse phases, character codes, register indexes, the token close record and a hex digit decode.
// No dependencies.
package hmtp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEIGHT = 3'd1,
        PH_COMMA  = 3'd2,
        PH_COLOR  = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;

    localparam logic [2:0] CFG_SEP_0     = 3'd0;
    localparam logic [2:0] CFG_SEP_1     = 3'd1;
    localparam logic [2:0] CFG_SEP_2     = 3'd2;
    localparam logic [2:0] CFG_SEP_3     = 3'd3;
    localparam logic [2:0] CFG_COL_COUNT = 3'd4;
    localparam logic [2:0] CFG_XY_SCALE  = 3'd5;
    localparam logic [2:0] CFG_Z_SCALE   = 3'd6;

    localparam logic [63:0] SEP_MASK_0_RST = 64'h0000_0001_0000_0400;

    // Token close record handed from the parser to the vertex stage
    typedef struct packed {
        logic        emit;
        logic [31:0] height;
        logic [31:0] color;
    } t_close;

    // Hex digit decode: bit 4 flags a digit, bits 3:0 carry its value
    function automatic logic [4:0] f_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CH_0 && b <= CH_9) begin
            r = {1'b1, 4'(b - CH_0)};
        end else if (b >= CH_UP_A && b <= CH_UP_F) begin
            r = {1'b1, 4'(b - CH_UP_A + 8'd10)};
        end else if (b >= CH_LOW_A && b <= CH_LOW_F) begin
            r = {1'b1, 4'(b - CH_LOW_A + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/hmtp_text_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces for the height map token parser: text bytes in, vertices out.
// No dependencies.
interface hmtp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface hmtp_vertex_if;
    logic               valid;
    logic               ready;
    logic        [31:0] token_index;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] height;
    logic        [31:0] color;
    logic signed [31:0] height_min;
    logic signed [31:0] height_max;

    modport source (output valid, output token_index, output x_pos, output y_pos,
                    output height, output color, output height_min, output height_max,
                    input ready);
    modport sink   (input valid, input token_index, input x_pos, input y_pos,
                    input height, input color, input height_min, input height_max,
                    output ready);
endinterface

// ----- rtl/hmtp_parse.sv -----
`timescale 1ns / 1ps
// Token parser: sign, height digits, optional comma and hex color per token.
// Depends on hmtp_pkg.
module hmtp_parse #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_fin,
    input  logic            i_sep,
    output hmtp_pkg::t_close o_close
);

    hmtp_pkg::t_phase         r_phase, n_phase;
    logic                     r_neg, n_neg;
    logic [VALUE_WIDTH-1:0]   r_acc, n_acc;
    logic [31:0]              r_color, n_color;
    logic                     r_pz, n_pz;
    logic                     r_ended, n_ended;

    // token state after this byte, before any close
    hmtp_pkg::t_phase         u_phase;
    logic                     u_neg;
    logic [VALUE_WIDTH-1:0]   u_acc;
    logic [31:0]              u_color;
    logic                     u_pz;

    logic [4:0]               dig;
    logic                     live;
    logic                     is_nul;
    logic                     emit;
    logic [VALUE_WIDTH-1:0]   signed_acc;

    assign dig    = hmtp_pkg::f_digit(i_byte);
    assign live   = i_step && !r_ended;
    assign is_nul = (i_byte == hmtp_pkg::CH_NUL);

    // byte update inside a token
    always_comb begin
        logic height_step;
        height_step = 1'b0;
        u_phase = r_phase;
        u_neg   = r_neg;
        u_acc   = r_acc;
        u_color = r_color;
        u_pz    = r_pz;
        case (r_phase)
            hmtp_pkg::PH_IDLE: begin
                u_phase = hmtp_pkg::PH_HEIGHT;
                if (i_byte == hmtp_pkg::CH_MINUS) begin
                    u_neg = 1'b1;
                end else if (i_byte != hmtp_pkg::CH_PLUS) begin
                    height_step = 1'b1;
                end
            end
            hmtp_pkg::PH_HEIGHT: height_step = 1'b1;
            hmtp_pkg::PH_COMMA: begin
                if (!dig[4]) begin
                    u_phase = hmtp_pkg::PH_SKIP;
                end else begin
                    u_color = {28'd0, dig[3:0]};
                    u_pz    = (dig[3:0] == 4'd0);
                    u_phase = hmtp_pkg::PH_COLOR;
                end
            end
            hmtp_pkg::PH_COLOR: begin
                u_pz = 1'b0;
                if (!(r_pz && (i_byte == hmtp_pkg::CH_LOW_X || i_byte == hmtp_pkg::CH_UP_X)))
                begin
                    if (!dig[4]) begin
                        u_phase = hmtp_pkg::PH_SKIP;
                    end else begin
                        u_color = {r_color[27:0], dig[3:0]};
                    end
                end
            end
            default: ;
        endcase
        if (height_step) begin
            if (dig[4]) begin
                u_acc = (r_acc << 3) + (r_acc << 1) + VALUE_WIDTH'(dig[3:0]);
            end else if (i_byte == hmtp_pkg::CH_COMMA) begin
                u_phase = hmtp_pkg::PH_COMMA;
            end else begin
                u_phase = hmtp_pkg::PH_SKIP;
            end
        end
    end

    // close decision
    always_comb begin
        if (is_nul || i_sep) begin
            emit = live && (r_phase != hmtp_pkg::PH_IDLE);
        end else begin
            emit = live && i_fin;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_color = r_color;
        n_pz    = r_pz;
        n_ended = r_ended;
        if (live) begin
            if (is_nul || i_fin) begin
                n_ended = 1'b1;
            end
            if (!is_nul && !i_sep) begin
                n_phase = u_phase;
                n_neg   = u_neg;
                n_acc   = u_acc;
                n_color = u_color;
                n_pz    = u_pz;
            end
            if (emit) begin
                n_phase = hmtp_pkg::PH_IDLE;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_color = 32'd0;
                n_pz    = 1'b0;
            end
        end
    end

    // outputs: on a separator or end byte the token holds its current state,
    // on a final data byte it carries this byte's update
    always_comb begin
        logic              sel_upd;
        logic              neg;
        logic [VALUE_WIDTH-1:0] acc;
        sel_upd = !is_nul && !i_sep;
        neg     = sel_upd ? u_neg : r_neg;
        acc     = sel_upd ? u_acc : r_acc;
        signed_acc     = neg ? (VALUE_WIDTH'(0) - acc) : acc;
        o_close.emit   = emit;
        o_close.height = 32'($signed(signed_acc));
        o_close.color  = sel_upd ? u_color : r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hmtp_pkg::PH_IDLE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_color <= 32'd0;
            r_pz    <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_color <= n_color;
            r_pz    <= n_pz;
            r_ended <= n_ended;
        end
    end

endmodule

// ----- rtl/height_map_token_parser_top.sv -----
`timescale 1ns / 1ps
// Height map token parser: one text byte per cycle in, one vertex per closed token out.
// Each byte passes the input register; the byte that closes a token loads its vertex into the
// result register, which drives the output. Throughput: 1 byte per cycle; the input stalls only
// while a held vertex waits on the output.
// Reset (synchronous, active low) clears the token state, counters and running extremes
// and loads the register defaults. Depends on hmtp_pkg, hmtp_text_if, hmtp_parse.
module height_map_token_parser_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hmtp_text_if.sink           i_text,
    hmtp_vertex_if.source       o_vertex,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    logic [63:0] r_sep_mask [4];
    logic [15:0] r_col_count;
    logic [15:0] r_xy_scale;
    logic [15:0] r_z_scale;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_fin;

    logic        r_out_vld;
    logic [31:0] r_out_index;
    logic [31:0] r_out_x;
    logic [31:0] r_out_y;
    logic [31:0] r_out_h;
    logic [31:0] r_out_color;

    logic [31:0] r_token_cnt;
    logic [15:0] r_col;
    logic [31:0] r_row;
    logic [31:0] r_min, n_min;
    logic [31:0] r_max, n_max;

    logic        advance;
    logic        accept;
    logic        step;
    logic        sep;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [15:0] cols;
    logic [15:0] col_inc;
    hmtp_pkg::t_close close;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_comb begin
        case (reg_idx)
            hmtp_pkg::CFG_SEP_0:     prdata = r_sep_mask[0];
            hmtp_pkg::CFG_SEP_1:     prdata = r_sep_mask[1];
            hmtp_pkg::CFG_SEP_2:     prdata = r_sep_mask[2];
            hmtp_pkg::CFG_SEP_3:     prdata = r_sep_mask[3];
            hmtp_pkg::CFG_COL_COUNT: prdata = {48'd0, r_col_count};
            hmtp_pkg::CFG_XY_SCALE:  prdata = {48'd0, r_xy_scale};
            hmtp_pkg::CFG_Z_SCALE:   prdata = {48'd0, r_z_scale};
            default:                 prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_mask[0] <= hmtp_pkg::SEP_MASK_0_RST;
            r_sep_mask[1] <= 64'd0;
            r_sep_mask[2] <= 64'd0;
            r_sep_mask[3] <= 64'd0;
            r_col_count   <= 16'd1;
            r_xy_scale    <= 16'd1;
            r_z_scale     <= 16'd1;
        end else if (wr_en) begin
            case (reg_idx)
                hmtp_pkg::CFG_SEP_0:     r_sep_mask[0] <= pwdata;
                hmtp_pkg::CFG_SEP_1:     r_sep_mask[1] <= pwdata;
                hmtp_pkg::CFG_SEP_2:     r_sep_mask[2] <= pwdata;
                hmtp_pkg::CFG_SEP_3:     r_sep_mask[3] <= pwdata;
                hmtp_pkg::CFG_COL_COUNT: r_col_count   <= pwdata[15:0];
                hmtp_pkg::CFG_XY_SCALE:  r_xy_scale    <= pwdata[15:0];
                hmtp_pkg::CFG_Z_SCALE:   r_z_scale     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    assign advance      = !r_out_vld || o_vertex.ready;
    assign i_text.ready = !r_in_vld || advance;
    assign accept       = i_text.valid && i_text.ready;
    assign step         = r_in_vld && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text.text_byte;
            r_in_fin  <= i_text.final_byte;
        end
    end

    assign sep = r_sep_mask[r_in_byte[7:6]][r_in_byte[5:0]];

    hmtp_parse #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .i_sep   (sep),
        .o_close (close)
    );

    // ---------------- vertex stage ----------------
    assign cols    = (r_col_count == 16'd0) ? 16'd1 : r_col_count;
    assign col_inc = r_col + 16'd1;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if ($signed(close.height) < $signed(r_min)) begin
            n_min = close.height;
        end
        if ($signed(close.height) > $signed(r_max)) begin
            n_max = close.height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_cnt <= 32'd0;
            r_col       <= 16'd0;
            r_row       <= 32'd0;
            r_min       <= 32'h7FFF_FFFF;
            r_max       <= 32'h8000_0000;
        end else if (step && close.emit) begin
            r_token_cnt <= r_token_cnt + 32'd1;
            r_min       <= n_min;
            r_max       <= n_max;
            if (col_inc >= cols) begin
                r_col <= 16'd0;
                r_row <= r_row + 32'd1;
            end else begin
                r_col <= col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && close.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_vertex.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && close.emit) begin
            r_out_index <= r_token_cnt;
            r_out_x     <= {16'd0, r_col} * {16'd0, r_xy_scale};
            r_out_y     <= 32'(r_row * {16'd0, r_xy_scale});
            r_out_h     <= 32'(close.height * {{16{r_z_scale[15]}}, r_z_scale});
            r_out_color <= close.color;
        end
    end

    // running extremes already include the vertex held in the output register
    assign o_vertex.valid       = r_out_vld;
    assign o_vertex.token_index = r_out_index;
    assign o_vertex.x_pos       = r_out_x;
    assign o_vertex.y_pos       = r_out_y;
    assign o_vertex.height      = r_out_h;
    assign o_vertex.color       = r_out_color;
    assign o_vertex.height_min  = r_min;
    assign o_vertex.height_max  = r_max;

    // ---------------- checks ----------------
    a_emit_loads_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && close.emit |=> r_out_vld && r_out_index == $past(r_token_cnt))
        else $error("vertex index does not match token count");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && close.emit |=> r_token_cnt == $past(r_token_cnt) + 32'd1)
        else $error("token count did not advance on close");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_cnt != 32'd0 |-> $signed(r_min) <= $signed(r_max))
        else $error("running min above running max");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_vertex.ready |-> !step)
        else $error("parser advanced while a vertex was held");

endmodule

// ----- sim/hmtp_vertex_checker.sv -----
`timescale 1ns / 1ps
// Vertex checker for the height map token parser: follows register writes and accepted
// text bytes, predicts every vertex and compares it with what the block emits.
// Depends on hmtp_pkg and the hmtp_text_if / hmtp_vertex_if channels.
module hmtp_vertex_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmtp_text_if        i_text,
    hmtp_vertex_if      i_vertex,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [5:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] token_index;
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [31:0] height;
        logic [31:0] color;
        logic [31:0] height_min;
        logic [31:0] height_max;
    } t_vertex;

    // register copy
    logic [63:0] sep_mask [4];
    logic [15:0] col_limit;
    logic [15:0] xy_scale;
    logic [15:0] z_scale;

    // token and map state
    hmtp_pkg::t_phase   phase;
    logic               negative;
    logic [31:0]        height_acc;
    logic [31:0]        color_acc;
    logic               zero_prefix;
    logic [31:0]        vertex_count;
    logic [15:0]        column;
    logic [31:0]        row;
    logic signed [31:0] lowest;
    logic signed [31:0] highest;
    logic               text_done;

    t_vertex pending_vertices [$];
    int      mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int hex_value(input logic [7:0] b);
        if (b >= hmtp_pkg::CH_0 && b <= hmtp_pkg::CH_9) return int'(b - hmtp_pkg::CH_0);
        if (b >= hmtp_pkg::CH_UP_A && b <= hmtp_pkg::CH_UP_F) begin
            return int'(b - hmtp_pkg::CH_UP_A) + 10;
        end
        if (b >= hmtp_pkg::CH_LOW_A && b <= hmtp_pkg::CH_LOW_F) begin
            return int'(b - hmtp_pkg::CH_LOW_A) + 10;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [31:0] index);
        if (got !== want) begin
            report_mismatch($sformatf("vertex %0d %s: got %h, expected %h",
                                      index, name, got, want));
        end
    endtask

    task automatic clear_token();
        phase       = hmtp_pkg::PH_IDLE;
        negative    = 1'b0;
        height_acc  = '0;
        color_acc   = '0;
        zero_prefix = 1'b0;
    endtask

    task automatic add_height_char(input logic [7:0] b);
        int d;
        d = hex_value(b);
        if (d >= 0) begin
            height_acc = height_acc * 32'd10 + 32'(d);
        end else if (b == hmtp_pkg::CH_COMMA) begin
            phase = hmtp_pkg::PH_COMMA;
        end else begin
            phase = hmtp_pkg::PH_SKIP;
        end
    endtask

    task automatic close_vertex();
        t_vertex     v;
        logic [31:0] h;
        logic [15:0] wrap;
        h = negative ? -height_acc : height_acc;
        if ($signed(h) < lowest) lowest = h;
        if ($signed(h) > highest) highest = h;
        v.token_index = vertex_count;
        v.x_pos       = {16'd0, column} * {16'd0, xy_scale};
        v.y_pos       = row * {16'd0, xy_scale};
        v.height      = h * {{16{z_scale[15]}}, z_scale};
        v.color       = color_acc;
        v.height_min  = lowest;
        v.height_max  = highest;
        pending_vertices.push_back(v);
        vertex_count = vertex_count + 32'd1;
        // a column count of zero wraps like one
        wrap   = (col_limit == 16'd0) ? 16'd1 : col_limit;
        column = column + 16'd1;
        if (column >= wrap) begin
            column = '0;
            row    = row + 32'd1;
        end
        clear_token();
    endtask

    task automatic predict_text_byte(input logic [7:0] b, input logic fin);
        int d;
        d = hex_value(b);
        if (text_done) return;
        if (b == hmtp_pkg::CH_NUL) begin
            text_done = 1'b1;
            if (phase != hmtp_pkg::PH_IDLE) close_vertex();
            return;
        end
        // a separator always ends the token, whatever the character
        if (sep_mask[b[7:6]][b[5:0]]) begin
            if (fin) text_done = 1'b1;
            if (phase != hmtp_pkg::PH_IDLE) close_vertex();
            return;
        end
        case (phase)
            hmtp_pkg::PH_IDLE: begin
                phase = hmtp_pkg::PH_HEIGHT;
                if (b == hmtp_pkg::CH_MINUS) begin
                    negative = 1'b1;
                end else if (b != hmtp_pkg::CH_PLUS) begin
                    add_height_char(b);
                end
            end
            hmtp_pkg::PH_HEIGHT: add_height_char(b);
            hmtp_pkg::PH_COMMA: begin
                if (d < 0) begin
                    phase = hmtp_pkg::PH_SKIP;
                end else begin
                    color_acc   = 32'(d);
                    zero_prefix = (d == 0);
                    phase       = hmtp_pkg::PH_COLOR;
                end
            end
            hmtp_pkg::PH_COLOR: begin
                // drop the x of a 0x prefix right after the comma
                if (zero_prefix && (b == hmtp_pkg::CH_LOW_X || b == hmtp_pkg::CH_UP_X)) begin
                    zero_prefix = 1'b0;
                end else begin
                    zero_prefix = 1'b0;
                    if (d < 0) begin
                        phase = hmtp_pkg::PH_SKIP;
                    end else begin
                        color_acc = (color_acc << 4) + 32'(d);
                    end
                end
            end
            default: ;
        endcase
        if (fin) begin
            text_done = 1'b1;
            close_vertex();
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            sep_mask[0]  = hmtp_pkg::SEP_MASK_0_RST;
            sep_mask[1]  = '0;
            sep_mask[2]  = '0;
            sep_mask[3]  = '0;
            col_limit    = 16'd1;
            xy_scale     = 16'd1;
            z_scale      = 16'd1;
            clear_token();
            vertex_count = '0;
            column       = '0;
            row          = '0;
            lowest       = 32'h7FFF_FFFF;
            highest      = 32'h8000_0000;
            text_done    = 1'b0;
            pending_vertices.delete();
        end else begin
            if (i_vertex.valid && i_vertex.ready) begin
                if (pending_vertices.size() == 0) begin
                    report_mismatch($sformatf("vertex with no prediction, token_index %0d",
                                              i_vertex.token_index));
                end else begin
                    want = pending_vertices.pop_front();
                    check_field("token_index", i_vertex.token_index, want.token_index,
                                want.token_index);
                    check_field("x_pos", i_vertex.x_pos, want.x_pos, want.token_index);
                    check_field("y_pos", i_vertex.y_pos, want.y_pos, want.token_index);
                    check_field("height", i_vertex.height, want.height, want.token_index);
                    check_field("color", i_vertex.color, want.color, want.token_index);
                    check_field("height_min", i_vertex.height_min, want.height_min,
                                want.token_index);
                    check_field("height_max", i_vertex.height_max, want.height_max,
                                want.token_index);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    hmtp_pkg::CFG_SEP_0, hmtp_pkg::CFG_SEP_1,
                    hmtp_pkg::CFG_SEP_2, hmtp_pkg::CFG_SEP_3: begin
                        sep_mask[i_paddr[4:3]] = i_pwdata;
                    end
                    hmtp_pkg::CFG_COL_COUNT: col_limit = i_pwdata[15:0];
                    hmtp_pkg::CFG_XY_SCALE:  xy_scale  = i_pwdata[15:0];
                    hmtp_pkg::CFG_Z_SCALE:   z_scale   = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_text.valid && i_text.ready) begin
                predict_text_byte(i_text.text_byte, i_text.final_byte);
            end
        end
        o_pending = pending_vertices.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Top of the height map token parser bench: clock, reset, register writes, text stimulus
// and output stalls; the vertex checker beside the block predicts and compares.
// Depends on hmtp_pkg, the channel interfaces, the block and hmtp_vertex_checker.
module testbench;

    localparam int          ITEM_TARGET   = 1650;
    localparam int          IDLE_LIMIT    = 4000;
    localparam logic [63:0] ALL_ONES      = '1;
    // '+', ',', '-' and the decimal digits
    localparam logic [63:0] TOKEN_CHARS_0 = 64'h03FF_3800_0000_0000;
    // 'A'-'F', 'X', 'a'-'f', 'x'
    localparam logic [63:0] TOKEN_CHARS_1 = 64'h0100_007E_0100_007E;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    hmtp_text_if   text_ch ();
    hmtp_vertex_if vertex_ch ();

    int fail_count;
    int pending;
    int items_sent;
    int tx_calm;
    int rx_calm;
    int idle_cycles;

    // masks as last written, used to pick separator bytes
    logic [63:0] stim_sep [4];
    logic [7:0]  separators [$];

    height_map_token_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_ch),
        .o_vertex (vertex_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hmtp_vertex_checker vertex_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (text_ch),
        .i_vertex     (vertex_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random wait with occasional stretches of none
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [63:0] sparse_bits();
        return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return hmtp_pkg::CH_0 + 8'(r);
        if (r < 16) return hmtp_pkg::CH_UP_A + 8'(r - 10);
        return hmtp_pkg::CH_LOW_A + 8'(r - 16);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= b;
        text_ch.final_byte <= fin;
        do @(posedge i_clk); while (!text_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic note_separators();
        separators.delete();
        for (int b = 1; b < 256; b++) begin
            if (stim_sep[b / 64][b % 64]) separators.push_back(8'(b));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] s0, input logic [63:0] s1,
                              input logic [63:0] s2, input logic [63:0] s3,
                              input logic [15:0] cols, input logic [15:0] xy,
                              input logic [15:0] z);
        // hold the text until every vertex is out and the pipeline has drained
        text_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(hmtp_pkg::CFG_SEP_0, s0);
        write_reg(hmtp_pkg::CFG_SEP_1, s1);
        write_reg(hmtp_pkg::CFG_SEP_2, s2);
        write_reg(hmtp_pkg::CFG_SEP_3, s3);
        write_reg(hmtp_pkg::CFG_COL_COUNT, {48'd0, cols});
        write_reg(hmtp_pkg::CFG_XY_SCALE, {48'd0, xy});
        write_reg(hmtp_pkg::CFG_Z_SCALE, {48'd0, z});
        stim_sep[0] = s0;
        stim_sep[1] = s1;
        stim_sep[2] = s2;
        stim_sep[3] = s3;
        note_separators();
    endtask

    task automatic send_token(input bit well_formed);
        logic [7:0] q [$];
        int         n;
        if (well_formed) begin
            case ($urandom_range(0, 3))
                0: q.push_back(hmtp_pkg::CH_MINUS);
                1: q.push_back(hmtp_pkg::CH_PLUS);
                default: ;
            endcase
            // long digit runs can wrap the height
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
            repeat (n) q.push_back(pick_hex());
            if ($urandom_range(0, 1)) begin
                q.push_back(hmtp_pkg::CH_COMMA);
                case ($urandom_range(0, 3))
                    0: begin
                        q.push_back(hmtp_pkg::CH_0);
                        q.push_back(hmtp_pkg::CH_LOW_X);
                    end
                    1: begin
                        q.push_back(hmtp_pkg::CH_0);
                        q.push_back(hmtp_pkg::CH_UP_X);
                    end
                    default: ;
                endcase
                n = $urandom_range(0, 9);
                repeat (n) q.push_back(pick_hex());
            end
            if ($urandom_range(0, 9) == 0) q.push_back(8'($urandom_range(1, 255)));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                case ($urandom_range(0, 4))
                    0: q.push_back(hmtp_pkg::CH_MINUS);
                    1: q.push_back(hmtp_pkg::CH_COMMA);
                    2: q.push_back($urandom_range(0, 1) ? hmtp_pkg::CH_LOW_X
                                                        : hmtp_pkg::CH_UP_X);
                    3: q.push_back(pick_hex());
                    default: q.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end
        foreach (q[i]) send_byte(q[i], 1'b0);
        if (separators.size() > 0) begin
            repeat ($urandom_range(1, 2)) begin
                send_byte(separators[$urandom_range(0, separators.size() - 1)], 1'b0);
            end
        end
    endtask

    task automatic run_tokens(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) send_token($urandom_range(0, 4) != 0);
    endtask

    // receiver: a random stall, possibly none, before each vertex, then take it
    initial begin
        int stall;
        vertex_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                vertex_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            vertex_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!vertex_ch.valid);
            @(negedge i_clk);
        end
    end

    // watchdog: end the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((text_ch.valid && text_ch.ready) || (vertex_ch.valid && vertex_ch.ready) ||
                (psel && penable) || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [63:0] m0;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] m3;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.final_byte = 1'b0;
        items_sent         = 0;
        tx_calm            = 0;
        rx_calm            = 0;
        stim_sep[0]        = hmtp_pkg::SEP_MASK_0_RST;
        stim_sep[1]        = '0;
        stim_sep[2]        = '0;
        stim_sep[3]        = '0;
        note_separators();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: negative hex-letter height with 0X color, sign in mid-token,
        // all-ones height, token that opens with a comma
        send_text("-9a,0Xf1 +1-2 4294967295\n,x ");

        // comma, minus and a digit as separators; zero column count
        set_config(hmtp_pkg::SEP_MASK_0_RST | (64'd1 << hmtp_pkg::CH_COMMA) |
                   (64'd1 << hmtp_pkg::CH_MINUS) | (64'd1 << (hmtp_pkg::CH_0 + 8'd5)),
                   '0, '0, '0, 16'd0, 16'hFFFF, 16'h8000);
        run_tokens(120);
        // only high bytes split tokens
        set_config('0, '0, ALL_ONES, ALL_ONES, 16'hFFFF, 16'd0, 16'h7FFF);
        run_tokens(120);
        // every byte below 64 is a separator, digits and comma among them: tokens hold no digits
        set_config(ALL_ONES, sparse_bits(), '0, '0, 16'd1, 16'd1, 16'd0);
        run_tokens(100);
        set_config(hmtp_pkg::SEP_MASK_0_RST, ALL_ONES, '0, '0, 16'd3, 16'd2, 16'hFFFF);
        run_tokens(100);
        // every byte splits: no vertices
        set_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 16'd2, 16'd5, 16'd3);
        run_tokens(30);

        while (items_sent < ITEM_TARGET) begin
            m0 = hmtp_pkg::SEP_MASK_0_RST | sparse_bits();
            m1 = sparse_bits();
            m2 = sparse_bits();
            m3 = sparse_bits();
            if ($urandom_range(0, 3) != 0) begin
                m0 = m0 & ~TOKEN_CHARS_0;
                m1 = m1 & ~TOKEN_CHARS_1;
            end
            set_config(m0, m1, m2, m3,
                       ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 9)),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 16)) : 16'($urandom),
                       16'($urandom));
            run_tokens(150);
        end

        // close the text with an open token
        case ($urandom_range(0, 2))
            0: begin
                send_text("12");
                send_byte(hmtp_pkg::CH_NUL, 1'b0);
            end
            1: begin
                send_text("-3");
                send_byte((separators.size() > 0) ? separators[0] : hmtp_pkg::CH_NUL, 1'b1);
            end
            default: begin
                send_text("5,0x");
                send_byte(hmtp_pkg::CH_LOW_A, 1'b1);
            end
        endcase
        // dropped after the end of the text
        repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        text_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
